// File: rtl/glpmc_pkg.sv
// Types and constants shared by the gesture long-press mode controller.
package glpmc_pkg;

  // Gesture codes from the sensor
  localparam logic [3:0] GEST_NONE     = 4'd0;
  localparam logic [3:0] GEST_UP       = 4'd1;
  localparam logic [3:0] GEST_DOWN     = 4'd2;
  localparam logic [3:0] GEST_LEFT     = 4'd3;
  localparam logic [3:0] GEST_RIGHT    = 4'd4;
  localparam logic [3:0] GEST_FORWARD  = 4'd5;
  localparam logic [3:0] GEST_BACKWARD = 4'd6;

  // Servo targets in degrees
  localparam logic [7:0] ANGLE_LEFT   = 8'd0;
  localparam logic [7:0] ANGLE_RIGHT  = 8'd180;
  localparam logic [7:0] ANGLE_CENTER = 8'd90;

  // Register indexes on the config port (byte address bits [3:2])
  localparam logic [1:0] REG_LONG_PRESS_TIME = 2'd0;
  localparam logic [1:0] REG_LATCH_TIMEOUT   = 2'd1;
  localparam logic [1:0] REG_RECORD_LIMIT    = 2'd2;

  // Register reset values
  localparam logic [15:0] LONG_PRESS_TIME_RST = 16'd1000;
  localparam logic [15:0] LATCH_TIMEOUT_RST   = 16'd2000;
  localparam logic [10:0] RECORD_LIMIT_RST    = 11'd64;

  typedef enum logic [1:0] {
    MODE_CONTROL  = 2'd0,
    MODE_RECORD   = 2'd1,
    MODE_PLAYBACK = 2'd2,
    MODE_MENU     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_MENU_ENTER = 3'd1,
    ACT_REC_START  = 3'd2,
    ACT_REC_STOP   = 3'd3,
    ACT_PLAY_START = 3'd4,
    ACT_PLAY_STOP  = 3'd5,
    ACT_PLAY_DONE  = 3'd6,
    ACT_MENU_EXIT  = 3'd7
  } action_t;

  // One poll from the gesture sensor, recorder and menu
  typedef struct packed {
    logic [3:0]  gesture;
    logic [31:0] tick_ms;
    logic [10:0] recorded_count;
    logic        playback_done;
    logic        menu_exit_request;
  } poll_t;

  // One result item
  typedef struct packed {
    logic        long_press;
    mode_t       mode;
    logic        servo_valid;
    logic [7:0]  servo_angle;
    action_t     action;
    logic        record_valid;
    logic        record_full;
  } result_t;

  // Servo angle for a gesture; bit 8 flags a mapped direction
  function automatic logic [8:0] angle_of(input logic [3:0] g);
    logic [8:0] r;
    case (g)
      GEST_LEFT:  r = {1'b1, ANGLE_LEFT};
      GEST_RIGHT: r = {1'b1, ANGLE_RIGHT};
      GEST_UP:    r = {1'b1, ANGLE_CENTER};
      GEST_DOWN:  r = {1'b1, ANGLE_CENTER};
      default:    r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/gesture_long_press_mode_controller_core.sv
// Gesture long-press detector and four-mode servo/recorder controller.
//
// Usage:
//   poll channel (poll_valid/poll_ready/poll): one item per sensor poll with
//   gesture code, millisecond tick and recorder/menu status flags.
//   result channel (result_valid/result_ready/result): one item per poll with
//   the long-press flag, mode after the poll, servo target and commands.
//   APB port: long_press_time at 0x0, latch_timeout at 0x4, record_limit at
//   0x8; pready is tied high, reads return the current register value.
// Timing:
//   Each accepted poll is evaluated in the cycle it is accepted and its result
//   is registered; result_valid rises on the next cycle.
//   Throughput is one poll per cycle while each result is taken, set by the
//   single result register; the latch, hold and mode state have their own.
//   When the receiver stalls, the result register holds its item and
//   poll_ready drops until it is taken; a poll is taken in the same cycle the
//   held result leaves.
// Reset:
//   Synchronous rst clears the mode (control), latch/hold state, previous
//   codes and result_valid, and loads the register reset values.
module gesture_long_press_mode_controller_core (
  input  logic                clk,
  input  logic                rst,
  // poll channel
  input  logic                poll_valid,
  output logic                poll_ready,
  input  glpmc_pkg::poll_t    poll,
  // result channel
  output logic                result_valid,
  input  logic                result_ready,
  output glpmc_pkg::result_t  result,
  // config port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import glpmc_pkg::*;

  // config registers
  logic [15:0] long_press_time;
  logic [15:0] latch_timeout;
  logic [10:0] record_limit;

  // controller state
  mode_t       mode_reg;
  logic [3:0]  latched_code;
  logic [31:0] latch_time;
  logic [3:0]  held_code;
  logic [31:0] hold_start;
  logic        press_reported;
  logic [3:0]  prev_control_code;
  logic [3:0]  prev_record_code;
  logic [3:0]  recent_valid_code;

  mode_t       mode_reg_next;
  logic [3:0]  latched_code_next;
  logic [31:0] latch_time_next;
  logic [3:0]  held_code_next;
  logic [31:0] hold_start_next;
  logic        press_reported_next;
  logic [3:0]  prev_control_code_next;
  logic [3:0]  prev_record_code_next;
  logic [3:0]  recent_valid_code_next;
  result_t     result_next;

  logic        poll_fire;
  logic        cfg_write;

  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign poll_ready = !result_valid || result_ready;
  assign poll_fire  = poll_valid && poll_ready;

  // config write
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_time <= LONG_PRESS_TIME_RST;
      latch_timeout   <= LATCH_TIMEOUT_RST;
      record_limit    <= RECORD_LIMIT_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_LONG_PRESS_TIME: long_press_time <= pwdata[15:0];
        REG_LATCH_TIMEOUT:   latch_timeout   <= pwdata[15:0];
        REG_RECORD_LIMIT:    record_limit    <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // config readback
  always_comb begin
    case (paddr[3:2])
      REG_LONG_PRESS_TIME: prdata = {16'd0, long_press_time};
      REG_LATCH_TIMEOUT:   prdata = {16'd0, latch_timeout};
      REG_RECORD_LIMIT:    prdata = {21'd0, record_limit};
      default:             prdata = 32'd0;
    endcase
  end

  // per-poll evaluation: long-press detection, then the mode controller
  always_comb begin
    logic [31:0] since_latch;
    logic [31:0] since_hold;
    logic        hit;
    logic [3:0]  g;
    logic [8:0]  ang;

    g           = poll.gesture;
    since_latch = poll.tick_ms - latch_time;
    since_hold  = poll.tick_ms - hold_start;
    hit         = 1'b0;
    ang         = angle_of(g);

    latched_code_next      = latched_code;
    latch_time_next        = latch_time;
    held_code_next         = held_code;
    hold_start_next        = hold_start;
    press_reported_next    = press_reported;
    mode_reg_next          = mode_reg;
    prev_control_code_next = prev_control_code;
    prev_record_code_next  = prev_record_code;
    recent_valid_code_next = recent_valid_code;

    result_next = '0;

    // gesture latch with timeout
    if (g != GEST_NONE) begin
      latched_code_next = g;
      latch_time_next   = poll.tick_ms;
    end else if (latched_code != GEST_NONE && since_latch > {16'd0, latch_timeout}) begin
      latched_code_next = GEST_NONE;
    end

    // hold tracking, long press reported once per hold
    if (latched_code_next != GEST_NONE) begin
      if (latched_code_next == held_code) begin
        if (since_hold >= {16'd0, long_press_time} && !press_reported) begin
          hit                 = 1'b1;
          press_reported_next = 1'b1;
        end
      end else begin
        held_code_next      = latched_code_next;
        hold_start_next     = poll.tick_ms;
        press_reported_next = 1'b0;
      end
    end else begin
      held_code_next      = GEST_NONE;
      hold_start_next     = poll.tick_ms;
      press_reported_next = 1'b0;
    end

    // mode controller
    case (mode_reg)
      MODE_CONTROL: begin
        if (g != GEST_NONE) recent_valid_code_next = g;
        if (g != prev_control_code || hit) begin
          prev_control_code_next = g;
          if (hit) begin
            if (recent_valid_code_next == GEST_FORWARD) begin
              mode_reg_next          = MODE_MENU;
              result_next.action     = ACT_MENU_ENTER;
              recent_valid_code_next = GEST_NONE;
            end else if (recent_valid_code_next == GEST_UP) begin
              mode_reg_next          = MODE_RECORD;
              result_next.action     = ACT_REC_START;
              prev_record_code_next  = GEST_NONE;
              recent_valid_code_next = GEST_NONE;
            end else if (recent_valid_code_next == GEST_DOWN) begin
              // playback needs something recorded
              if (poll.recorded_count != 11'd0) begin
                mode_reg_next      = MODE_PLAYBACK;
                result_next.action = ACT_PLAY_START;
              end
              recent_valid_code_next = GEST_NONE;
            end
          end else if (g != GEST_NONE && ang[8]) begin
            result_next.servo_valid = 1'b1;
            result_next.servo_angle = ang[7:0];
          end
        end
      end
      MODE_RECORD: begin
        if (g != GEST_NONE) recent_valid_code_next = g;
        if (hit && (recent_valid_code_next == GEST_UP ||
                    recent_valid_code_next == GEST_DOWN)) begin
          mode_reg_next          = MODE_CONTROL;
          result_next.action     = ACT_REC_STOP;
          recent_valid_code_next = GEST_NONE;
        end else if (g != prev_record_code) begin
          prev_record_code_next = g;
          if (g != GEST_NONE && ang[8]) begin
            result_next.servo_valid = 1'b1;
            result_next.servo_angle = ang[7:0];
            if (poll.recorded_count < record_limit) result_next.record_valid = 1'b1;
            else result_next.record_full = 1'b1;
          end
        end
      end
      MODE_PLAYBACK: begin
        if (g != GEST_NONE) recent_valid_code_next = g;
        if (hit && (recent_valid_code_next == GEST_FORWARD ||
                    recent_valid_code_next == GEST_BACKWARD)) begin
          mode_reg_next          = MODE_CONTROL;
          result_next.action     = ACT_PLAY_STOP;
          recent_valid_code_next = GEST_NONE;
        end else if (poll.playback_done) begin
          mode_reg_next      = MODE_CONTROL;
          result_next.action = ACT_PLAY_DONE;
        end
      end
      MODE_MENU: begin
        if (poll.menu_exit_request) begin
          mode_reg_next      = MODE_CONTROL;
          result_next.action = ACT_MENU_EXIT;
        end
      end
      default: ;
    endcase

    result_next.long_press = hit;
    result_next.mode       = mode_reg_next;
  end

  // state update on each accepted poll
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg          <= MODE_CONTROL;
      latched_code      <= GEST_NONE;
      latch_time        <= '0;
      held_code         <= GEST_NONE;
      hold_start        <= '0;
      press_reported    <= 1'b0;
      prev_control_code <= GEST_NONE;
      prev_record_code  <= GEST_NONE;
      recent_valid_code <= GEST_NONE;
    end else if (poll_fire) begin
      mode_reg          <= mode_reg_next;
      latched_code      <= latched_code_next;
      latch_time        <= latch_time_next;
      held_code         <= held_code_next;
      hold_start        <= hold_start_next;
      press_reported    <= press_reported_next;
      prev_control_code <= prev_control_code_next;
      prev_record_code  <= prev_record_code_next;
      recent_valid_code <= recent_valid_code_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (poll_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_fire) begin
      result <= result_next;
    end
  end

  // checks
  a_held_tracks_latch: assert property (@(posedge clk) disable iff (rst)
    held_code == latched_code)
    else $error("held code diverged from latched code");

  a_press_marked: assert property (@(posedge clk) disable iff (rst)
    poll_fire && result_next.long_press |=> press_reported)
    else $error("long press not marked as reported");

  a_menu_entry: assert property (@(posedge clk) disable iff (rst)
    poll_fire && mode_reg != MODE_MENU && mode_reg_next == MODE_MENU
      |-> result_next.action == ACT_MENU_ENTER)
    else $error("menu entered without menu enter action");

  a_record_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.record_valid || result.record_full)
      |-> result.servo_valid && result.mode == MODE_RECORD
          && !(result.record_valid && result.record_full))
    else $error("inconsistent record flags");

endmodule
